// File: rtl/core/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants of the affine transform stack
// Term widths, fraction bits, stack sizing, command and status codes, and
// the matrix, product and control structures used across the core.
// ----------------------------------------------------------------------------
package afs_pkg;

   localparam int TERM_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int COORD_W     = 16;
   localparam int FUNC_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int DEPTH_W     = 4;
   localparam int STACK_DEPTH = 8;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PROD_W      = 2 * TERM_W;
   localparam int SUM_W       = PROD_W + 2;

   localparam logic signed [TERM_W-1:0] Q_ONE      = TERM_W'(1 << FRAC_BITS);
   localparam logic signed [TERM_W-1:0] AXIS_LIMIT =
      TERM_W'(((1 << FRAC_BITS) + 999) / 1000);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TRANSLATE = 3'd0,
      FUNC_ROTATE    = 3'd1,
      FUNC_SCALE     = 3'd2,
      FUNC_PUSH      = 3'd3,
      FUNC_POP       = 3'd4,
      FUNC_MAP       = 3'd5,
      FUNC_RESET     = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] a;
      logic signed [TERM_W-1:0] b;
      logic signed [TERM_W-1:0] c;
      logic signed [TERM_W-1:0] d;
      logic signed [TERM_W-1:0] e;
      logic signed [TERM_W-1:0] f;
   } matrix_type;

   localparam matrix_type MATRIX_IDENTITY = '{
      a: Q_ONE, b: '0, c: '0, d: Q_ONE, e: '0, f: '0
   };

   typedef struct packed {
      logic signed [PROD_W-1:0] m0;  // a * first
      logic signed [PROD_W-1:0] m1;  // c * second
      logic signed [PROD_W-1:0] m2;  // b * first
      logic signed [PROD_W-1:0] m3;  // d * second
      logic signed [PROD_W-1:0] m4;  // a * second
      logic signed [PROD_W-1:0] m5;  // c * first
      logic signed [PROD_W-1:0] m6;  // b * second
      logic signed [PROD_W-1:0] m7;  // d * first
   } prod_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              restore;
   } calc_ctl_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic                      axis_aligned;
      status_type                status;
      logic [DEPTH_W-1:0]        depth_now;
   } rsp_type;

endpackage

// File: rtl/core/afs_if.sv
// ----------------------------------------------------------------------------
// afs_if: request and response channels of the affine transform stack
// Valid/ready channels carrying the command request and the mapped result.
// ----------------------------------------------------------------------------
interface afs_req_if import afs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [TERM_W-1:0] first_operand;
   logic signed [TERM_W-1:0] second_operand;

   modport source (output valid, output func, output first_operand,
                   output second_operand, input ready);
   modport sink   (input valid, input func, input first_operand,
                   input second_operand, output ready);
endinterface

interface afs_rsp_if import afs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic                      axis_aligned;
   logic [STATUS_W-1:0]       status;
   logic [DEPTH_W-1:0]        depth_now;

   modport source (output valid, output out_x, output out_y, output axis_aligned,
                   output status, output depth_now, input ready);
   modport sink   (input valid, input out_x, input out_y, input axis_aligned,
                   input status, input depth_now, output ready);
endinterface

// File: rtl/core/affine_transform_stack.sv
// ----------------------------------------------------------------------------
// affine_transform_stack: 2D affine matrix unit with a matrix stack
// Requests pass through the product registers, then the update stage into the
// response register. 1 request per cycle unless responses stall; a request
// behind a matrix write (translate, rotate, scale, successful pop, reset) waits.
// Synchronous reset loads the identity matrix, empties the stack and drops
// requests in flight; the stack memory keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
module affine_transform_stack import afs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   afs_req_if.sink    req_if,
   afs_rsp_if.source  rsp_if
);

   matrix_type           matrix_ff, matrix_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   matrix_type           stack_mem [STACK_DEPTH];
   matrix_type           pop_data_ff;

   prod_type             prod_ff, prod_in;
   logic                 s1_valid_ff, s1_valid_in;
   calc_ctl_type         s1_ctl_ff, s1_ctl_in;
   status_type           s1_status_ff, s1_status_in;
   logic [DEPTH_W-1:0]   s1_depth_ff, s1_depth_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_accept;
   logic                 s1_advance;
   logic                 s1_writes;
   logic                 push_ok;
   logic                 pop_ok;
   status_type           cmd_status;
   logic [LEVEL_W-1:0]   cmd_level;
   logic [LEVEL_W-1:0]   level_dec;
   logic [ADDR_W-1:0]    push_addr;
   logic [ADDR_W-1:0]    pop_addr;
   matrix_type           calc_nxt;
   point_type            calc_pt;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      case (func_type'(s1_ctl_ff.func))
         FUNC_TRANSLATE, FUNC_ROTATE, FUNC_SCALE, FUNC_RESET: s1_writes = 1'b1;
         FUNC_POP: s1_writes = s1_ctl_ff.restore;
         default:  s1_writes = 1'b0;
      endcase
   end

   // hold new requests while the matrix register is being rewritten or the first stage stalls
   assign req_if.ready = !s1_valid_ff || (s1_advance && !s1_writes);
   assign req_accept   = req_if.valid && req_if.ready;

   assign level_dec = level_ff - LEVEL_W'(1);
   assign push_addr = level_ff[ADDR_W-1:0];
   assign pop_addr  = level_dec[ADDR_W-1:0];

   always_comb begin
      push_ok    = 1'b0;
      pop_ok     = 1'b0;
      cmd_status = STATUS_OK;
      cmd_level  = level_ff;
      case (func_type'(req_if.func))
         FUNC_PUSH: begin
            if (level_ff < LEVEL_W'(STACK_DEPTH)) begin
               push_ok   = 1'b1;
               cmd_level = level_ff + LEVEL_W'(1);
            end else begin
               cmd_status = STATUS_FULL;
            end
         end
         FUNC_POP: begin
            if (level_ff != '0) begin
               pop_ok    = 1'b1;
               cmd_level = level_dec;
            end else begin
               cmd_status = STATUS_EMPTY;
            end
         end
         FUNC_RESET: cmd_level = '0;
         default: begin
         end
      endcase
   end

   always_comb begin
      prod_in.m0 = matrix_ff.a * req_if.first_operand;
      prod_in.m1 = matrix_ff.c * req_if.second_operand;
      prod_in.m2 = matrix_ff.b * req_if.first_operand;
      prod_in.m3 = matrix_ff.d * req_if.second_operand;
      prod_in.m4 = matrix_ff.a * req_if.second_operand;
      prod_in.m5 = matrix_ff.c * req_if.first_operand;
      prod_in.m6 = matrix_ff.b * req_if.second_operand;
      prod_in.m7 = matrix_ff.d * req_if.first_operand;
   end

   always_comb begin
      level_in     = req_accept ? cmd_level : level_ff;
      s1_ctl_in    = '{func: req_if.func, restore: pop_ok};
      s1_status_in = cmd_status;
      s1_depth_in  = DEPTH_W'(cmd_level);
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   afs_term_calc u_calc (
      .ctl   (s1_ctl_ff),
      .cur   (matrix_ff),
      .saved (pop_data_ff),
      .prod  (prod_ff),
      .nxt   (calc_nxt),
      .pt    (calc_pt)
   );

   always_comb begin
      matrix_in           = s1_advance ? calc_nxt : matrix_ff;
      rsp_in.out_x        = calc_pt.x;
      rsp_in.out_y        = calc_pt.y;
      rsp_in.axis_aligned = (calc_nxt.b > -AXIS_LIMIT) && (calc_nxt.b < AXIS_LIMIT) &&
                            (calc_nxt.c > -AXIS_LIMIT) && (calc_nxt.c < AXIS_LIMIT);
      rsp_in.status       = s1_status_ff;
      rsp_in.depth_now    = s1_depth_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && push_ok) begin
         stack_mem[push_addr] <= matrix_ff;
      end
      if (req_accept && pop_ok) begin
         pop_data_ff <= stack_mem[pop_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff    <= MATRIX_IDENTITY;
         level_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matrix_ff    <= matrix_in;
         level_ff     <= level_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         prod_ff      <= prod_in;
         s1_ctl_ff    <= s1_ctl_in;
         s1_status_ff <= s1_status_in;
         s1_depth_ff  <= s1_depth_in;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_x        = rsp_ff.out_x;
   assign rsp_if.out_y        = rsp_ff.out_y;
   assign rsp_if.axis_aligned = rsp_ff.axis_aligned;
   assign rsp_if.status       = rsp_ff.status;
   assign rsp_if.depth_now    = rsp_ff.depth_now;

endmodule

// File: rtl/core/afs_term_calc.sv
// ----------------------------------------------------------------------------
// afs_term_calc: matrix update and point mapping from registered products
// Sums product pairs, applies floor shift or truncation toward zero, and
// saturates into new matrix terms or 16-bit mapped coordinates.
// ----------------------------------------------------------------------------
module afs_term_calc import afs_pkg::*; (
   input  calc_ctl_type ctl,
   input  matrix_type   cur,
   input  matrix_type   saved,
   input  prod_type     prod,
   output matrix_type   nxt,
   output point_type    pt
);

   function automatic logic signed [TERM_W-1:0] sat_term(
      input logic signed [SUM_W-1:0] v);
      if (&v[SUM_W-1:TERM_W-1] || ~|v[SUM_W-1:TERM_W-1]) begin
         return v[TERM_W-1:0];
      end
      return v[SUM_W-1] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
   endfunction

   function automatic logic signed [TERM_W-1:0] lin_term(
      input logic signed [SUM_W-1:0] v);
      return sat_term(v >>> FRAC_BITS);
   endfunction

   function automatic logic signed [COORD_W-1:0] trunc_coord(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] q;
      q = v >>> FRAC_BITS;
      if (v[SUM_W-1] && |v[FRAC_BITS-1:0]) begin
         q = q + SUM_W'(1);
      end
      if (&q[SUM_W-1:COORD_W-1] || ~|q[SUM_W-1:COORD_W-1]) begin
         return q[COORD_W-1:0];
      end
      return q[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

   logic signed [SUM_W-1:0] sum_a;
   logic signed [SUM_W-1:0] sum_b;
   logic signed [SUM_W-1:0] sum_c;
   logic signed [SUM_W-1:0] sum_d;
   logic signed [SUM_W-1:0] sum_x;
   logic signed [SUM_W-1:0] sum_y;

   assign sum_a = SUM_W'(prod.m0) + SUM_W'(prod.m1);
   assign sum_b = SUM_W'(prod.m2) + SUM_W'(prod.m3);
   assign sum_c = SUM_W'(prod.m5) - SUM_W'(prod.m4);
   assign sum_d = SUM_W'(prod.m7) - SUM_W'(prod.m6);
   assign sum_x = sum_a + SUM_W'(cur.e);
   assign sum_y = sum_b + SUM_W'(cur.f);

   always_comb begin
      nxt = cur;
      pt  = '0;
      case (func_type'(ctl.func))
         FUNC_TRANSLATE: begin
            nxt.e = sat_term(sum_x);
            nxt.f = sat_term(sum_y);
         end
         FUNC_ROTATE: begin
            nxt.a = lin_term(sum_a);
            nxt.b = lin_term(sum_b);
            nxt.c = lin_term(sum_c);
            nxt.d = lin_term(sum_d);
         end
         FUNC_SCALE: begin
            nxt.a = lin_term(SUM_W'(prod.m0));
            nxt.b = lin_term(SUM_W'(prod.m2));
            nxt.c = lin_term(SUM_W'(prod.m5));
            nxt.d = lin_term(SUM_W'(prod.m7));
         end
         FUNC_POP: begin
            if (ctl.restore) begin
               nxt = saved;
            end
         end
         FUNC_MAP: begin
            pt.x = trunc_coord(sum_x);
            pt.y = trunc_coord(sum_y);
         end
         FUNC_RESET: begin
            nxt = MATRIX_IDENTITY;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: tb/sv/affine_transform_stack_tb.sv
// ----------------------------------------------------------------------------
// affine_transform_stack_tb: self-checking bench for the affine transform stack
// Walks a short table of directed requests (identity, extremes, saturation,
// full and empty stack) and then a long random mix of nested push/pop and
// transform sequences with some raw noise. Responses are checked against a
// bit-accurate matrix predictor or fixed row values, with random idling on both channels.
// ----------------------------------------------------------------------------
module affine_transform_stack_tb import afs_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;
   localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
   localparam int RANDOM_REQUESTS = 1450;

   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic signed [TERM_W-1:0] first;
      logic signed [TERM_W-1:0] second;
      bit                       has_want;
      rsp_type                  want;
   } cmd_row_type;

   logic clock;
   logic reset;

   afs_req_if req_if ();
   afs_rsp_if rsp_if ();

   affine_transform_stack dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   matrix_type  track_m;
   matrix_type  track_stack [STACK_DEPTH];
   int unsigned track_depth;

   rsp_type     pending_results [$];
   cmd_row_type directed_rows [$];

   int  errors;
   int  n_checked;
   int  n_sent;
   int  n_full;
   int  n_empty;
   int  n_axis;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint sat_add64(input longint x, input longint y);
      logic signed [65:0] s;
      s = x;
      s = s + y;
      if (s > I64_MAX) return I64_MAX;
      if (s < I64_MIN) return I64_MIN;
      return longint'(s);
   endfunction

   function automatic int sat32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
   endfunction

   function automatic int lin_term(input longint p, input longint q,
                                   input longint r, input longint s);
      return sat32(sat_add64(p * q, r * s) >>> FRAC_BITS);
   endfunction

   function automatic longint affine_sum(input longint p, input longint x,
                                         input longint r, input longint y,
                                         input longint t);
      return sat_add64(sat_add64(p * x, r * y), t);
   endfunction

   function automatic logic signed [COORD_W-1:0] trunc_coord(input longint v);
      logic signed [65:0] w;
      longint q;
      if (v >= 0) begin
         q = v >>> FRAC_BITS;
      end else begin
         w = v;
         w = -w;
         w = w >>> FRAC_BITS;
         q = -longint'(w);
      end
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return COORD_W'(q);
   endfunction

   function automatic bit tiny_term(input logic signed [TERM_W-1:0] t);
      longint m;
      m = t;
      if (m < 0) m = -m;
      return (m * 1000) < (64'sd1 <<< FRAC_BITS);
   endfunction

   function automatic rsp_type advance_matrix(input cmd_row_type c);
      rsp_type r;
      longint a, b, cc, d, e, g, p, q;
      a  = track_m.a;
      b  = track_m.b;
      cc = track_m.c;
      d  = track_m.d;
      e  = track_m.e;
      g  = track_m.f;
      p  = c.first;
      q  = c.second;
      r  = '0;
      r.status = STATUS_OK;
      case (c.func)
         FUNC_TRANSLATE: begin
            track_m.e = sat32(affine_sum(a, p, cc, q, e));
            track_m.f = sat32(affine_sum(b, p, d, q, g));
         end
         FUNC_ROTATE: begin
            track_m.a = lin_term(a, p, cc, q);
            track_m.b = lin_term(b, p, d, q);
            track_m.c = lin_term(a, -q, cc, p);
            track_m.d = lin_term(b, -q, d, p);
         end
         FUNC_SCALE: begin
            track_m.a = lin_term(a, p, 0, 0);
            track_m.b = lin_term(b, p, 0, 0);
            track_m.c = lin_term(cc, p, 0, 0);
            track_m.d = lin_term(d, p, 0, 0);
         end
         FUNC_PUSH: begin
            if (track_depth < STACK_DEPTH) begin
               track_stack[track_depth] = track_m;
               track_depth++;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         FUNC_POP: begin
            if (track_depth > 0) begin
               track_depth--;
               track_m = track_stack[track_depth];
            end else begin
               r.status = STATUS_EMPTY;
            end
         end
         FUNC_MAP: begin
            r.out_x = trunc_coord(affine_sum(a, p, cc, q, e));
            r.out_y = trunc_coord(affine_sum(b, p, d, q, g));
         end
         FUNC_RESET: begin
            track_m     = MATRIX_IDENTITY;
            track_depth = 0;
         end
         default: ;
      endcase
      r.axis_aligned = tiny_term(track_m.b) && tiny_term(track_m.c);
      r.depth_now    = DEPTH_W'(track_depth);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic cmd_row_type cmd(input logic [FUNC_W-1:0] f, input int p,
                                       input int q);
      cmd_row_type c;
      c.func     = f;
      c.first    = p;
      c.second   = q;
      c.has_want = 1'b0;
      c.want     = '0;
      return c;
   endfunction

   function automatic cmd_row_type cmd_want(input logic [FUNC_W-1:0] f, input int p,
                                            input int q, input int x, input int y,
                                            input bit ax, input status_type st,
                                            input int dep);
      cmd_row_type c;
      c = cmd(f, p, q);
      c.has_want          = 1'b1;
      c.want.out_x        = COORD_W'(x);
      c.want.out_y        = COORD_W'(y);
      c.want.axis_aligned = ax;
      c.want.status       = st;
      c.want.depth_now    = DEPTH_W'(dep);
      return c;
   endfunction

   function automatic int draw_gap();
      return no_idle ? 0 : int'($urandom_range(0, 4));
   endfunction

   function automatic int spread(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic send_request(input cmd_row_type c);
      rsp_type p;
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.func           <= c.func;
      req_if.first_operand  <= c.first;
      req_if.second_operand <= c.second;
      do @(posedge clock); while (!req_if.ready);
      p = advance_matrix(c);
      if (p.status == STATUS_FULL) n_full++;
      if (p.status == STATUS_EMPTY) n_empty++;
      if (p.axis_aligned) n_axis++;
      pending_results.push_back(c.has_want ? c.want : p);
      n_sent++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic cmd_row_type random_cmd(ref int push_run);
      int pick;
      int f;
      if (push_run > 0) begin
         push_run--;
         return cmd(FUNC_PUSH, $urandom, $urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return cmd(FUNC_TRANSLATE, spread(200), spread(200));
      if (pick < 20)
         return cmd(FUNC_ROTATE, Q_ONE + spread(40), spread(80));
      if (pick < 30)
         return cmd(FUNC_ROTATE, spread(65536), spread(65536));
      if (pick < 40) begin
         f = $urandom_range(32768, 131072);
         if ($urandom_range(0, 3) == 0) f = -f;
         return cmd(FUNC_SCALE, f, $urandom);
      end
      if (pick < 54)
         return cmd(FUNC_PUSH, $urandom, $urandom);
      if (pick < 55) begin
         push_run = $urandom_range(6, 10);
         return cmd(FUNC_PUSH, $urandom, $urandom);
      end
      if (pick < 70)
         return cmd(FUNC_POP, $urandom, $urandom);
      if (pick < 90)
         return cmd(FUNC_MAP, spread(1000), spread(1000));
      if (pick < 94)
         return cmd(FUNC_RESET, $urandom, $urandom);
      return cmd(3'($urandom_range(0, 7)), $urandom, $urandom);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic check_response();
      rsp_type w;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected response, expected none, actual x %0d y %0d status %0d",
                  $time, rsp_if.out_x, rsp_if.out_y, rsp_if.status);
         errors++;
      end else begin
         w = pending_results.pop_front();
         report("out_x", w.out_x, rsp_if.out_x);
         report("out_y", w.out_y, rsp_if.out_y);
         report("axis_aligned", w.axis_aligned, rsp_if.axis_aligned);
         report("status", w.status, rsp_if.status);
         report("depth_now", w.depth_now, rsp_if.depth_now);
      end
      n_checked++;
   endtask

   initial begin
      int gap;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         check_response();
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int push_run;
      errors      = 0;
      n_checked   = 0;
      n_sent      = 0;
      n_full      = 0;
      n_empty     = 0;
      n_axis      = 0;
      no_idle     = 1'b0;
      push_run    = 0;
      track_m     = MATRIX_IDENTITY;
      track_depth = 0;

      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.func           <= FUNC_TRANSLATE;
      req_if.first_operand  <= '0;
      req_if.second_operand <= '0;

      directed_rows.push_back(cmd_want(FUNC_MAP, 0, 0, 0, 0, 1, STATUS_OK, 0));
      directed_rows.push_back(cmd_want(FUNC_MAP, 100, -200, 100, -200, 1, STATUS_OK, 0));
      directed_rows.push_back(cmd_want(FUNC_MAP, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                       32767, -32768, 1, STATUS_OK, 0));
      directed_rows.push_back(cmd_want(FUNC_POP, 0, 0, 0, 0, 1, STATUS_EMPTY, 0));
      directed_rows.push_back(cmd_want(FUNC_SPARE, -1, -1, 0, 0, 1, STATUS_OK, 0));
      directed_rows.push_back(cmd(FUNC_TRANSLATE, 3, -5));
      directed_rows.push_back(cmd(FUNC_ROTATE, 46341, 46341));
      directed_rows.push_back(cmd(FUNC_MAP, 10, 10));
      directed_rows.push_back(cmd(FUNC_SCALE, 131072, 0));
      directed_rows.push_back(cmd(FUNC_SCALE, 32'sh8000_0000, 32'sh7FFF_FFFF));
      directed_rows.push_back(cmd(FUNC_ROTATE, 32'sh7FFF_FFFF, 32'sh8000_0000));
      directed_rows.push_back(cmd(FUNC_TRANSLATE, 32'sh7FFF_FFFF, 32'sh8000_0000));
      directed_rows.push_back(cmd(FUNC_MAP, 32'sh8000_0000, 32'sh7FFF_FFFF));
      directed_rows.push_back(cmd_want(FUNC_RESET, -1, 0, 0, 0, 1, STATUS_OK, 0));
      repeat (STACK_DEPTH) directed_rows.push_back(cmd(FUNC_PUSH, 0, 0));
      directed_rows.push_back(cmd_want(FUNC_PUSH, 0, 0, 0, 0, 1, STATUS_FULL, STACK_DEPTH));
      directed_rows.push_back(cmd(FUNC_ROTATE, 0, 65536));
      directed_rows.push_back(cmd(FUNC_POP, 0, 0));
      directed_rows.push_back(cmd_want(FUNC_RESET, 0, -1, 0, 0, 1, STATUS_OK, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);
      drain_results();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (i % 250 == 249) drain_results();
         send_request(random_cmd(push_run));
      end
      req_if.valid <= 1'b0;

      do @(posedge clock); while (pending_results.size() != 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses: %0d full-stack pushes,",
               n_sent, n_checked, n_full);
      $display("%0d empty pops and %0d axis-aligned results.", n_empty, n_axis);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
